// File: hw/rtl/spn_pkg.sv
// Shared types, constants and the sigmoid segment table for the sigmoid neuron.
package spn_pkg;

    typedef enum logic [1:0] {
        FUNC_WEIGHT = 2'd0,
        FUNC_BIAS   = 2'd1,
        FUNC_FEED   = 2'd2,
        FUNC_TRAIN  = 2'd3
    } t_func;

    // register index, taken from paddr[2]
    localparam logic REG_LEARNING_RATE = 1'b0;

    localparam logic [15:0] LR_RESET = 16'd6554;

    localparam int unsigned MUL_A_W = 34;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned MUL_P_W = 51;

    localparam logic [15:0] SIG_TOP = 16'd65514;

    typedef struct packed {
        logic                        en;
        logic signed [MUL_A_W-1:0]   a;
        logic signed [MUL_B_W-1:0]   b;
    } t_mul_op;

    // sigmoid(k/4) in Q0.16 for k = 0..32
    function automatic logic [15:0] sig_entry(input logic [5:0] k);
        logic [15:0] y;
        case (k)
            6'd0:  y = 16'd32768;
            6'd1:  y = 16'd36843;
            6'd2:  y = 16'd40793;
            6'd3:  y = 16'd44511;
            6'd4:  y = 16'd47911;
            6'd5:  y = 16'd50941;
            6'd6:  y = 16'd53581;
            6'd7:  y = 16'd55834;
            6'd8:  y = 16'd57724;
            6'd9:  y = 16'd59287;
            6'd10: y = 16'd60565;
            6'd11: y = 16'd61598;
            6'd12: y = 16'd62428;
            6'd13: y = 16'd63090;
            6'd14: y = 16'd63615;
            6'd15: y = 16'd64030;
            6'd16: y = 16'd64357;
            6'd17: y = 16'd64614;
            6'd18: y = 16'd64816;
            6'd19: y = 16'd64974;
            6'd20: y = 16'd65097;
            6'd21: y = 16'd65194;
            6'd22: y = 16'd65269;
            6'd23: y = 16'd65328;
            6'd24: y = 16'd65374;
            6'd25: y = 16'd65410;
            6'd26: y = 16'd65438;
            6'd27: y = 16'd65459;
            6'd28: y = 16'd65476;
            6'd29: y = 16'd65489;
            6'd30: y = 16'd65500;
            6'd31: y = 16'd65508;
            default: y = SIG_TOP;
        endcase
        return y;
    endfunction

endpackage

// File: hw/rtl/sigmoid_perceptron_neuron_top.sv
// Sigmoid neuron: weight RAM, bias, accumulator, shared multiplier and sequencer.
//
// Input channel (i_valid/o_ready) carries one transaction per element: write weight,
// write bias, feed element or train element. o_ready is high only while the
// sequencer is idle. Output channel (o_valid/i_ready) carries the activation and the
// saturated weighted sum, produced by a feed element marked last.
// Sequencer steps per input transaction, counted from acceptance to ready again:
//   write weight / write bias : done at acceptance, the sequencer stays idle
//   feed element (not last)   : weight read, multiply, accumulate
//   feed element (last)       : adds bias add, sigmoid magnitude, segment,
//                               interpolation multiply, output load
//   train element             : rate*delta, times element, round and write back
// These steps are set by the single shared multiplier and the registered weight RAM read port.
// The result is written to an output register; the sequencer waits in its last
// state only while that register still holds an untaken result.
// Reset clears the sequencer, accumulator and bias, sets learning_rate to 6554 and
// drops o_valid. The weight RAM is not cleared: weights are undefined until written.
// APB register at address 0: learning_rate, unsigned Q0.16.
module sigmoid_perceptron_neuron_top #(
    parameter int MAX_WEIGHTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic [5:0]          i_index,
    input  logic signed [15:0]  i_value,
    input  logic signed [15:0]  i_delta,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [15:0]         o_activation,
    output logic signed [31:0]  o_weighted_sum
);
    import spn_pkg::*;

    localparam int AW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_FMUL  = 11'b000_0000_0010,
        ST_FACC  = 11'b000_0000_0100,
        ST_FBIAS = 11'b000_0000_1000,
        ST_SMAG  = 11'b000_0001_0000,
        ST_SDIF  = 11'b000_0010_0000,
        ST_SMUL  = 11'b000_0100_0000,
        ST_SOUT  = 11'b000_1000_0000,
        ST_TRATE = 11'b001_0000_0000,
        ST_TSTEP = 11'b010_0000_0000,
        ST_TUPD  = 11'b100_0000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [15:0]                r_lr;
    logic [AW-1:0]              r_addr;
    logic                       r_ok;
    logic signed [15:0]         r_value;
    logic signed [15:0]         r_delta;
    logic                       r_last;
    logic signed [15:0]         r_wrd;
    logic signed [39:0]         r_acc, n_acc;
    logic signed [15:0]         r_bias, n_bias;
    logic signed [31:0]         r_sum, n_sum;
    logic                       r_neg;
    logic                       r_sat;
    logic [4:0]                 r_seg;
    logic [21:0]                r_frac;
    logic signed [16:0]         r_d;
    logic [15:0]                r_y0;
    logic signed [32:0]         r_rd;
    logic                       r_ovalid;
    logic [15:0]                r_act, n_act;
    logic signed [31:0]         r_wsum;
    logic signed [15:0]         n_wnew;

    logic signed [15:0]         mem [MAX_WEIGHTS];

    t_func                      in_func;
    logic                       accept;
    logic                       in_ok;
    logic [AW+5:0]              in_ext;
    logic [AW-1:0]              in_addr;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic signed [15:0]         mem_wdata;
    logic                       out_load;
    t_mul_op                    mul_op;
    logic signed [MUL_P_W-1:0]  mul_p;

    logic signed [40:0]         acc_sum;
    logic signed [40:0]         bias_sum;
    logic [32:0]                mag;
    logic [5:0]                 k0, k1;
    logic [16:0]                y_int;
    logic signed [MUL_P_W-1:0]  step_rnd;
    logic signed [22:0]         w_step;
    logic signed [23:0]         w_diff;
    logic signed [33:0]         rd_rnd;
    logic signed [17:0]         b_step;
    logic signed [18:0]         b_diff;

    spn_mul u_mul (
        .i_clk (i_clk),
        .i_op  (mul_op),
        .o_p   (mul_p)
    );

    assign in_func  = t_func'(i_func);
    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_ok    = ({26'd0, i_index} < 32'(MAX_WEIGHTS));
    assign in_ext   = (AW+6)'(i_index);
    assign in_addr  = in_ext[AW-1:0];
    assign out_load = (r_state == ST_SOUT) && (!r_ovalid || i_ready);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LEARNING_RATE) ? {16'd0, r_lr} : 32'd0;

    assign o_valid        = r_ovalid;
    assign o_activation   = r_act;
    assign o_weighted_sum = r_wsum;

    // operand selection for the shared multiplier
    always_comb begin
        mul_op = '0;
        case (r_state)
            ST_FMUL: begin
                mul_op.en = 1'b1;
                mul_op.a  = r_ok ? MUL_A_W'(r_wrd) : '0;
                mul_op.b  = MUL_B_W'(r_value);
            end
            ST_TRATE: begin
                mul_op.en = 1'b1;
                mul_op.a  = $signed({18'd0, r_lr});
                mul_op.b  = MUL_B_W'(r_delta);
            end
            ST_TSTEP: begin
                mul_op.en = 1'b1;
                mul_op.a  = $signed(mul_p[MUL_A_W-1:0]);
                mul_op.b  = MUL_B_W'(r_value);
            end
            ST_SMUL: begin
                mul_op.en = 1'b1;
                mul_op.a  = $signed({12'd0, r_frac});
                mul_op.b  = r_d;
            end
            default: begin
                mul_op = '0;
            end
        endcase
    end

    // datapath arithmetic
    always_comb begin
        acc_sum = 41'(r_acc) + 41'($signed(mul_p[31:0]));
        if (acc_sum[40] != acc_sum[39]) begin
            n_acc = acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
            n_acc = acc_sum[39:0];
        end

        bias_sum = 41'(r_acc) + 41'($signed({r_bias, 12'd0}));
        if ((&bias_sum[40:31]) || !(|bias_sum[40:31])) begin
            n_sum = bias_sum[31:0];
        end else begin
            n_sum = bias_sum[40] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end

        mag = r_sum[31] ? (33'd0 - 33'(r_sum)) : 33'(r_sum);
        k0  = {1'b0, r_seg};
        k1  = k0 + 6'd1;

        y_int = r_sat ? {1'b0, SIG_TOP} : (17'(r_y0) + 17'(mul_p[34:22]));
        n_act = r_neg ? 16'(17'h1_0000 - y_int) : y_int[15:0];

        // round half up to Q3.12, then saturate
        step_rnd = mul_p + 51'sd134217728;
        w_step   = step_rnd[50:28];
        w_diff   = 24'(r_wrd) - 24'(w_step);
        if ((&w_diff[23:15]) || !(|w_diff[23:15])) begin
            n_wnew = w_diff[15:0];
        end else begin
            n_wnew = w_diff[23] ? 16'sh8000 : 16'sh7fff;
        end

        rd_rnd = 34'(r_rd) + 34'sd32768;
        b_step = rd_rnd[33:16];
        b_diff = 19'(r_bias) - 19'(b_step);
        if ((&b_diff[18:15]) || !(|b_diff[18:15])) begin
            n_bias = b_diff[15:0];
        end else begin
            n_bias = b_diff[18] ? 16'sh8000 : 16'sh7fff;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_func)
                        FUNC_FEED:  n_state = ST_FMUL;
                        FUNC_TRAIN: n_state = ST_TRATE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FMUL:  n_state = ST_FACC;
            ST_FACC:  n_state = r_last ? ST_FBIAS : ST_IDLE;
            ST_FBIAS: n_state = ST_SMAG;
            ST_SMAG:  n_state = ST_SDIF;
            ST_SDIF:  n_state = ST_SMUL;
            ST_SMUL:  n_state = ST_SOUT;
            ST_SOUT:  n_state = out_load ? ST_IDLE : ST_SOUT;
            ST_TRATE: n_state = ST_TSTEP;
            ST_TSTEP: n_state = ST_TUPD;
            ST_TUPD:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // weight RAM: one write port, one registered read port
    always_comb begin
        if (accept) begin
            mem_we    = (in_func == FUNC_WEIGHT) && in_ok;
            mem_waddr = in_addr;
            mem_wdata = i_value;
        end else begin
            mem_we    = (r_state == ST_TUPD) && r_ok;
            mem_waddr = r_addr;
            mem_wdata = n_wnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_wrd <= mem[in_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_lr     <= LR_RESET;
            r_acc    <= '0;
            r_bias   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_LEARNING_RATE)) begin
                r_lr <= pwdata[15:0];
            end
            if (r_state == ST_FACC) begin
                r_acc <= n_acc;
            end else if (r_state == ST_FBIAS) begin
                r_acc <= '0;
            end
            if (accept && (in_func == FUNC_BIAS)) begin
                r_bias <= i_value;
            end else if ((r_state == ST_TUPD) && r_last) begin
                r_bias <= n_bias;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= in_addr;
            r_ok    <= in_ok;
            r_value <= i_value;
            r_delta <= i_delta;
            r_last  <= i_last;
        end
        if (r_state == ST_FBIAS) begin
            r_sum <= n_sum;
        end
        if (r_state == ST_SMAG) begin
            r_neg  <= r_sum[31];
            r_sat  <= |mag[32:27];
            r_seg  <= mag[26:22];
            r_frac <= mag[21:0];
        end
        if (r_state == ST_SDIF) begin
            r_y0 <= sig_entry(k0);
            r_d  <= $signed({1'b0, sig_entry(k1) - sig_entry(k0)});
        end
        if (r_state == ST_TSTEP) begin
            r_rd <= mul_p[32:0];
        end
        if (out_load) begin
            r_act  <= n_act;
            r_wsum <= r_sum;
        end
    end

    // a feed or train transaction leaves the sequencer busy in the cycle after acceptance
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((in_func == FUNC_FEED) || (in_func == FUNC_TRAIN))) |=> !o_ready)
        else $error("sequencer ready straight after a feed or train transaction");

    // a new result only comes out of the final sigmoid state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_SOUT))
        else $error("result raised outside the output state");

    // the accumulator is cleared by the time a result is presented
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (r_acc == '0))
        else $error("accumulator not cleared after a result");

endmodule

// File: hw/rtl/spn_mul.sv
// Shared signed 34x17 multiplier with a registered product.
module spn_mul (
    input  logic                    i_clk,
    input  spn_pkg::t_mul_op        i_op,
    output logic signed [50:0]      o_p
);
    import spn_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_p <= MUL_P_W'(i_op.a) * MUL_P_W'(i_op.b);
        end
    end

    assign o_p = r_p;

endmodule

// File: tb/sv/sigmoid_perceptron_neuron_tb.sv
// Self-checking testbench for the sigmoid neuron: directed rows, random passes, APB rate setup, accumulator overflow.
`timescale 1ns / 100ps

module tb;
    import spn_pkg::*;

    localparam int NUM_WEIGHTS    = 64;
    localparam int NUM_DIR        = 24;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 75;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [2:0] LR_ADDR = {REG_LEARNING_RATE, 2'b00};

    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -SUM_HI - 1;

    // sigmoid(k/4), k = 0..32, unsigned Q0.16
    localparam int SIG_LUT [33] = '{
        32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
        57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
        64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
        65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
        65514
    };

    typedef struct packed {
        t_func              func;
        logic [5:0]         idx;
        logic signed [15:0] value;
        logic signed [15:0] delta;
        logic               last;
    } t_elem;

    typedef struct packed {
        logic [15:0]        act;
        logic signed [31:0] wsum;
    } t_neuron_out;

    typedef struct packed {
        t_elem       elem;
        logic        typed;
        t_neuron_out out;
    } t_dir_row;

    localparam t_neuron_out NO_OUT = '0;

    // rows with typed = 1 carry their own expected result
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{'{FUNC_WEIGHT, 6'd0,  16'sh7FFF,   16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_WEIGHT, 6'd63, 16'sh8000,   16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_WEIGHT, 6'd1,  16'sd4096,   16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd1,  16'sd0,      16'sd0,      1'b1}, 1'b1,
          '{16'd32768, 32'sd0}},
        '{'{FUNC_FEED,   6'd63, 16'sh8000,   16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd63, 16'sh8000,   16'sd0,      1'b1}, 1'b1,
          '{16'd65514, 32'sh7FFF_FFFF}},
        '{'{FUNC_BIAS,   6'd0,  16'sh8000,   16'sd0,      1'b1}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd63, 16'sh7FFF,   16'sd0,      1'b1}, 1'b1,
          '{16'd22, -32'sd1207926784}},
        '{'{FUNC_FEED,   6'd1,  16'sd4096,   16'sh7FFF,   1'b1}, 1'b0, NO_OUT},
        '{'{FUNC_BIAS,   6'd0,  16'sd0,      16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_TRAIN,  6'd1,  16'sd4096,   16'sd4096,   1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_TRAIN,  6'd0,  16'sh8000,   16'sh8000,   1'b1}, 1'b0, NO_OUT},
        '{'{FUNC_TRAIN,  6'd63, 16'sh7FFF,   16'sh7FFF,   1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd1,  16'sd8192,   16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_WEIGHT, 6'd2,  16'sd100,    16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_TRAIN,  6'd2,  16'sd1,      16'sd1,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd2,  -16'sd4096,  16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd0,  16'sd4096,   16'sd0,      1'b1}, 1'b0, NO_OUT},
        '{'{FUNC_WEIGHT, 6'd3,  -16'sd1,     16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_TRAIN,  6'd3,  16'sh8000,   16'sh7FFF,   1'b1}, 1'b0, NO_OUT},
        '{'{FUNC_TRAIN,  6'd0,  16'sh8000,   16'sh7FFF,   1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_TRAIN,  6'd0,  16'sh8000,   16'sh7FFF,   1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd0,  16'sh7FFF,   16'sd0,      1'b0}, 1'b0, NO_OUT},
        '{'{FUNC_FEED,   6'd3,  -16'sd2048,  16'sd0,      1'b1}, 1'b0, NO_OUT}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [5:0]         i_index;
    logic signed [15:0] i_value;
    logic signed [15:0] i_delta;
    logic               i_last;
    logic               o_valid;
    logic               i_ready;
    logic [15:0]        o_activation;
    logic signed [31:0] o_weighted_sum;

    // predictor state
    logic [15:0]        lr;
    logic signed [15:0] wt [NUM_WEIGHTS];
    bit                 wt_known [NUM_WEIGHTS];
    logic signed [15:0] bias;
    longint             acc;

    t_neuron_out neuron_out_q [$];

    int errors;
    int items_sent;
    int max_gap;
    int max_stall;
    int idle_cycles;
    bit hold_req;

    sigmoid_perceptron_neuron_top #(
        .MAX_WEIGHTS (NUM_WEIGHTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_delta        (i_delta),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_activation   (o_activation),
        .o_weighted_sum (o_weighted_sum)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic logic [15:0] sigmoid_of(input logic signed [31:0] x);
        longint mag;
        longint seg;
        longint frac;
        longint y;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        seg = mag >>> 22;
        if (seg >= 32) begin
            y = longint'(SIG_TOP);
        end else begin
            // interpolate between neighbouring entries, truncate the fraction
            frac = mag & 64'h3F_FFFF;
            y = SIG_LUT[seg] + (((SIG_LUT[seg + 1] - SIG_LUT[seg]) * frac) >>> 22);
        end
        return (x < 0) ? 16'(65536 - y) : 16'(y);
    endfunction

    task automatic predict_neuron(input t_elem e, output bit has_out, output t_neuron_out r);
        longint rate_delta;
        longint sum;
        has_out = 1'b0;
        r = '0;
        case (e.func)
            FUNC_WEIGHT: begin
                wt[e.idx] = e.value;
                wt_known[e.idx] = 1'b1;
            end
            FUNC_BIAS: begin
                bias = e.value;
            end
            FUNC_FEED: begin
                acc = acc + longint'(wt[e.idx]) * longint'($signed(e.value));
                if (acc > ACC_HI) acc = ACC_HI;
                else if (acc < ACC_LO) acc = ACC_LO;
                if (e.last) begin
                    sum = acc + longint'(bias) * 4096;
                    if (sum > SUM_HI) sum = SUM_HI;
                    else if (sum < SUM_LO) sum = SUM_LO;
                    acc = 0;
                    r.wsum = 32'(sum);
                    r.act = sigmoid_of(r.wsum);
                    has_out = 1'b1;
                end
            end
            default: begin
                // round half up to Q3.12, then saturate the stored value
                rate_delta = longint'(lr) * longint'($signed(e.delta));
                wt[e.idx] = clip16(longint'(wt[e.idx]) -
                    ((rate_delta * longint'($signed(e.value)) + (64'sd1 <<< 27)) >>> 28));
                if (e.last)
                    bias = clip16(longint'(bias) - ((rate_delta + 64'sd32768) >>> 16));
            end
        endcase
    endtask

    function automatic logic signed [15:0] rnd_q16();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0, 1: return 16'($urandom_range(0, 65535));
            2: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return -16'sd1;
                    3: return 16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 16384)) - 8192);
        endcase
    endfunction

    task automatic offer(input t_elem e, input bit typed, input t_neuron_out typed_out);
        int gap;
        bit has_out;
        t_neuron_out r;
        gap = $urandom_range(0, max_gap);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= e.func;
        i_index <= e.idx;
        i_value <= e.value;
        i_delta <= e.delta;
        i_last  <= e.last;
        do @(posedge i_clk); while (!o_ready);
        predict_neuron(e, has_out, r);
        if (has_out)
            neuron_out_q = {neuron_out_q, (typed ? typed_out : r)};
        items_sent++;
    endtask

    // never read a weight that has not been written: load it first
    task automatic offer_elem(input t_func f, input logic [5:0] idx,
                              input logic signed [15:0] v, input logic signed [15:0] d,
                              input logic last);
        t_elem e;
        if ((f == FUNC_FEED || f == FUNC_TRAIN) && !wt_known[idx]) begin
            e.func = FUNC_WEIGHT;
            e.idx = idx;
            e.value = rnd_q16();
            e.delta = rnd_q16();
            e.last = 1'b0;
            offer(e, 1'b0, NO_OUT);
        end
        e.func = f;
        e.idx = idx;
        e.value = v;
        e.delta = d;
        e.last = last;
        offer(e, 1'b0, NO_OUT);
    endtask

    task automatic random_pass();
        int kind;
        int len;
        t_func f;
        t_func extra;
        logic signed [15:0] d;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
                offer_elem(FUNC_WEIGHT, 6'($urandom_range(0, 63)), rnd_q16(), rnd_q16(),
                           1'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0)
                offer_elem(FUNC_BIAS, 6'($urandom_range(0, 63)), rnd_q16(), rnd_q16(),
                           1'($urandom_range(0, 1)));
        end else if (kind < 9) begin
            f = (kind < 7) ? FUNC_FEED : FUNC_TRAIN;
            d = rnd_q16();
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                // slip a load or train transaction into the pass now and then
                if ($urandom_range(0, 7) == 0) begin
                    do extra = t_func'($urandom_range(0, 3)); while (extra == FUNC_FEED);
                    offer_elem(extra, 6'($urandom_range(0, 63)), rnd_q16(), rnd_q16(),
                               1'($urandom_range(0, 1)));
                end
                offer_elem(f, 6'($urandom_range(0, 63)), rnd_q16(),
                           (f == FUNC_TRAIN) ? d : rnd_q16(), k == len - 1);
            end
        end else begin
            offer_elem(t_func'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), rnd_q16(),
                       rnd_q16(), 1'($urandom_range(0, 1)));
        end
    endtask

    // drive the accumulator past one 40-bit limit, then back into the 32-bit range
    task automatic acc_overflow(input bit rising);
        t_elem e;
        e.func = FUNC_WEIGHT;
        e.idx = 6'd10;
        e.value = 16'sh8000;
        e.delta = 16'sd0;
        e.last = 1'b0;
        offer(e, 1'b0, NO_OUT);
        e.func = FUNC_FEED;
        e.value = rising ? 16'sh8000 : 16'sh7FFF;
        for (int k = 0; k < 520; k++)
            offer(e, 1'b0, NO_OUT);
        e.value = rising ? 16'sh7FFF : 16'sh8000;
        for (int k = 0; k < 512; k++) begin
            e.last = (k == 511);
            offer(e, 1'b0, NO_OUT);
        end
    endtask

    // drop valid and wait for the block to drain before touching the register
    task automatic settle_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (neuron_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [15:0] rate);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LR_ADDR;
        pwdata  <= {16'd0, rate};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        lr = rate;
        // read back straight after the write
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== rate) begin
            $error("learning_rate: expected %0d, got %0d", rate, prdata[15:0]);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        t_neuron_out want;
        i_ready <= 1'b0;
        wait (i_rst_n == 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, max_stall);
                if (stall != 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (neuron_out_q.size() == 0) begin
                $error("unexpected result: activation %0d, weighted_sum %0d",
                       o_activation, o_weighted_sum);
                errors++;
            end else begin
                want = neuron_out_q.pop_front();
                if (o_activation !== want.act) begin
                    $error("activation: expected %0d, got %0d", want.act, o_activation);
                    errors++;
                end
                if (o_weighted_sum !== want.wsum) begin
                    $error("weighted_sum: expected %0d, got %0d",
                           $signed(want.wsum), o_weighted_sum);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sigmoid_perceptron_neuron_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [15:0] rate;
        int start;
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_valid <= 1'b0;
        i_func  <= FUNC_WEIGHT;
        i_index <= '0;
        i_value <= '0;
        i_delta <= '0;
        i_last  <= 1'b0;
        idle_cycles = 0;
        errors = 0;
        items_sent = 0;
        hold_req = 1'b0;
        max_gap = 4;
        max_stall = 4;
        lr = LR_RESET;
        bias = '0;
        acc = 0;
        wt_known = '{default: 1'b0};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIR; k++)
            offer(DIR_ROWS[k].elem, DIR_ROWS[k].typed, DIR_ROWS[k].out);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_input();
            case (p)
                0: rate = 16'd0;
                1: rate = 16'hFFFF;
                2: rate = 16'd1;
                3: rate = 16'h8000;
                6: rate = LR_RESET;
                default: rate = 16'($urandom_range(0, 65535));
            endcase
            write_rate(rate);
            max_gap = (p % 3 == 1) ? 0 : 4;
            max_stall = (p % 3 == 1) ? 0 : 4;
            // keep offering while the result side holds off, so the input stalls
            if (p == 2) begin
                max_gap = 0;
                hold_req = 1'b1;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                random_pass();
        end

        settle_input();
        max_gap = 0;
        max_stall = 2;
        acc_overflow(1'b1);
        settle_input();

        if (errors == 0) begin
            $display("sigmoid_perceptron_neuron_top verification clean");
        end else begin
            $display("sigmoid_perceptron_neuron_top verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/spn_pkg.sv
hw/rtl/spn_mul.sv
hw/rtl/sigmoid_perceptron_neuron_top.sv
tb/sv/sigmoid_perceptron_neuron_tb.sv
